/* src/wpde_pkg.sv */
// wpde_pkg: shared types and constants for the ws2812 pixel duty encoder
// no dependencies; every other file of the block refers to it by scoped names

package wpde_pkg;

   // field widths
   localparam int CODE_W  = 10;
   localparam int INDEX_W = 10;
   localparam int COLOR_W = 24;
   localparam int PCT_W   = 8;
   localparam int SLOT_W  = 5;

   // csr map: byte address width, register indexes and reset values
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;
   localparam logic [1:0] REG_HIGH_CODE = 2'd0;
   localparam logic [1:0] REG_LOW_CODE  = 2'd1;
   localparam logic [1:0] REG_LED_COUNT = 2'd2;
   localparam logic [CODE_W-1:0]  HIGH_CODE_RST = 10'd240;
   localparam logic [CODE_W-1:0]  LOW_CODE_RST  = 10'd102;
   localparam logic [INDEX_W-1:0] LED_COUNT_RST = 10'd80;

   // floor(x / 100) for x < 2^16 as (x * 83887) >> 23
   localparam int RECIP_W = 17;
   localparam logic [RECIP_W-1:0] RECIP_MULT = 17'd83887;
   localparam int RECIP_SHIFT = 23;

   // last slot of a pixel (blue lsb)
   localparam logic [SLOT_W-1:0] SLOT_LAST = 5'd23;

   // configuration seen by front and back
   typedef struct packed {
      logic [CODE_W-1:0]  high_code;
      logic [CODE_W-1:0]  low_code;
      logic [INDEX_W-1:0] led_count;
   } cfg_type;

   // one scaled pixel waiting for serialization
   typedef struct packed {
      logic [INDEX_W-1:0] pixel_index;
      logic [COLOR_W-1:0] grb;
   } entry_type;

   // write side of the pixel queue
   typedef struct packed {
      logic      valid;
      entry_type entry;
   } push_type;

endpackage

/* src/wpde_csr.sv */
// wpde_csr: apb register file holding high_code, low_code and led_count
// depends on wpde_pkg

module wpde_csr (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wpde_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wpde_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wpde_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready,
   output wpde_pkg::cfg_type                   cfg
);

   logic [wpde_pkg::CODE_W-1:0]  high_ff, high_in;
   logic [wpde_pkg::CODE_W-1:0]  low_ff, low_in;
   logic [wpde_pkg::INDEX_W-1:0] count_ff, count_in;
   logic [1:0]                   reg_index;
   logic                         wr_en;

   assign reg_index  = csr_paddr[3:2];
   assign wr_en      = csr_psel & csr_penable & csr_pwrite & csr_pready;
   assign csr_pready = 1'b1;

   // write decode
   always_comb begin
      high_in  = high_ff;
      low_in   = low_ff;
      count_in = count_ff;
      if (wr_en) begin
         unique case (reg_index)
            wpde_pkg::REG_HIGH_CODE: high_in  = csr_pwdata[wpde_pkg::CODE_W-1:0];
            wpde_pkg::REG_LOW_CODE:  low_in   = csr_pwdata[wpde_pkg::CODE_W-1:0];
            wpde_pkg::REG_LED_COUNT: count_in = csr_pwdata[wpde_pkg::INDEX_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         high_ff  <= wpde_pkg::HIGH_CODE_RST;
         low_ff   <= wpde_pkg::LOW_CODE_RST;
         count_ff <= wpde_pkg::LED_COUNT_RST;
      end else begin
         high_ff  <= high_in;
         low_ff   <= low_in;
         count_ff <= count_in;
      end
   end

   // read mux
   always_comb begin
      unique case (reg_index)
         wpde_pkg::REG_HIGH_CODE: csr_prdata = 32'(high_ff);
         wpde_pkg::REG_LOW_CODE:  csr_prdata = 32'(low_ff);
         wpde_pkg::REG_LED_COUNT: csr_prdata = 32'(count_ff);
         default:                 csr_prdata = '0;
      endcase
   end

   assign cfg.high_code = high_ff;
   assign cfg.low_code  = low_ff;
   assign cfg.led_count = count_ff;

endmodule

/* src/wpde_front.sv */
// wpde_front: accepts pixel requests, drops out-of-range indices and scales
// the three channels by brightness in a two-stage multiply pipeline; uses wpde_pkg

module wpde_front #(
   parameter int QUEUE_DEPTH = 2,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [wpde_pkg::INDEX_W-1:0]      req_chain_pos,
   input  logic [wpde_pkg::COLOR_W-1:0]      req_color,
   input  logic [wpde_pkg::PCT_W-1:0]        req_brightness,
   input  wpde_pkg::cfg_type                 cfg,
   input  logic [CNT_W-1:0]                  q_count,
   output wpde_pkg::push_type                push
);

   localparam int OCC_W  = $clog2(QUEUE_DEPTH + 3);
   localparam int PROD_W = 16;
   localparam int WIDE_W = PROD_W + wpde_pkg::RECIP_W;

   logic                          accept;
   logic [OCC_W-1:0]              occupancy;
   logic [7:0]                    chan[3];
   logic [PROD_W-1:0]             s1_prod_in[3];
   logic [WIDE_W-1:0]             wide[3];
   logic [9:0]                    s2_quot_in[3];
   logic [7:0]                    sat[3];

   logic                          s1_valid_ff, s1_valid_in;
   logic [wpde_pkg::INDEX_W-1:0]  s1_index_ff;
   logic [PROD_W-1:0]             s1_prod_ff[3];
   logic                          s2_valid_ff;
   logic [wpde_pkg::INDEX_W-1:0]  s2_index_ff;
   logic [9:0]                    s2_quot_ff[3];

   // pixels in flight plus queued pixels bound what may still be taken
   assign occupancy = OCC_W'(s1_valid_ff) + OCC_W'(s2_valid_ff) + OCC_W'(q_count);
   assign busy      = (occupancy >= OCC_W'(QUEUE_DEPTH));
   assign accept    = start & ~busy;
   assign s1_valid_in = accept & (req_chain_pos < cfg.led_count);

   // channels in grb order
   assign chan[0] = req_color[15:8];
   assign chan[1] = req_color[23:16];
   assign chan[2] = req_color[7:0];

   // stage 1: channel times percent
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         s1_prod_in[k] = PROD_W'(chan[k]) * PROD_W'(req_brightness);
      end
   end

   // stage 2: divide by one hundred through the reciprocal
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         wide[k] = WIDE_W'(s1_prod_ff[k]) * WIDE_W'(wpde_pkg::RECIP_MULT);
         s2_quot_in[k] = wide[k][wpde_pkg::RECIP_SHIFT +: 10];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_index_ff <= req_chain_pos;
      s2_index_ff <= s1_index_ff;
      for (int k = 0; k < 3; k++) begin
         s1_prod_ff[k] <= s1_prod_in[k];
         s2_quot_ff[k] <= s2_quot_in[k];
      end
   end

   // saturate to eight bits and hand to the queue
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sat[k] = (s2_quot_ff[k] > 10'd255) ? 8'hFF : s2_quot_ff[k][7:0];
      end
   end

   assign push.valid             = s2_valid_ff;
   assign push.entry.pixel_index = s2_index_ff;
   assign push.entry.grb         = {sat[0], sat[1], sat[2]};

endmodule

/* src/wpde_queue.sv */
// wpde_queue: short fifo of scaled pixels between front and back
// depends on wpde_pkg; never written when full, since the front holds off requests

module wpde_queue #(
   parameter int QUEUE_DEPTH = 2,
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
   input  logic                  clock,
   input  logic                  reset,
   input  wpde_pkg::push_type    push,
   input  logic                  pop,
   output wpde_pkg::entry_type   head,
   output logic                  not_empty,
   output logic [CNT_W-1:0]      count
);

   localparam int PTR_W = $clog2(QUEUE_DEPTH);

   wpde_pkg::entry_type  mem_ff[QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic                 do_pop;

   assign do_pop = pop & (count_ff != '0);

   // pointer and count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      if (push.valid) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      unique case ({push.valid, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push.valid) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head      = mem_ff[rd_ptr_ff];
   assign not_empty = (count_ff != '0);
   assign count     = count_ff;

endmodule

/* src/wpde_back.sv */
// wpde_back: serializes one queued pixel into 24 duty codes, one per cycle
// depends on wpde_pkg

module wpde_back (
   input  logic                            clock,
   input  logic                            reset,
   input  wpde_pkg::cfg_type               cfg,
   input  wpde_pkg::entry_type             head,
   input  logic                            q_not_empty,
   output logic                            pop,
   output logic                            rsp_strobe,
   output logic [wpde_pkg::INDEX_W-1:0]    rsp_pixel_index,
   output logic [wpde_pkg::SLOT_W-1:0]     rsp_bit_slot,
   output logic [wpde_pkg::CODE_W-1:0]     rsp_duty_code,
   output logic                            rsp_last_code
);

   logic                          active_ff, active_in;
   logic [wpde_pkg::SLOT_W-1:0]   slot_ff, slot_in;
   logic [wpde_pkg::COLOR_W-1:0]  grb_ff, grb_in;
   logic [wpde_pkg::INDEX_W-1:0]  index_ff, index_in;
   logic                          at_last;

   assign at_last = (slot_ff == wpde_pkg::SLOT_LAST);

   // take the next pixel when idle or on the last slot of the current one
   assign pop = q_not_empty & (~active_ff | at_last);

   always_comb begin
      active_in = active_ff;
      slot_in   = slot_ff;
      grb_in    = grb_ff;
      index_in  = index_ff;
      if (pop) begin
         active_in = 1'b1;
         slot_in   = '0;
         grb_in    = head.grb;
         index_in  = head.pixel_index;
      end else if (active_ff) begin
         if (at_last) begin
            active_in = 1'b0;
         end else begin
            slot_in = slot_ff + 1'b1;
            grb_in  = {grb_ff[wpde_pkg::COLOR_W-2:0], 1'b0};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         slot_ff   <= '0;
      end else begin
         active_ff <= active_in;
         slot_ff   <= slot_in;
      end
   end

   always_ff @(posedge clock) begin
      grb_ff   <= grb_in;
      index_ff <= index_in;
   end

   // result port, msb of the shifting word picks the code
   assign rsp_strobe      = active_ff;
   assign rsp_pixel_index = index_ff;
   assign rsp_bit_slot    = slot_ff;
   assign rsp_duty_code   = grb_ff[wpde_pkg::COLOR_W-1] ? cfg.high_code : cfg.low_code;
   assign rsp_last_code   = at_last;

endmodule

/* src/ws2812_pixel_duty_encoder.sv */
// ws2812_pixel_duty_encoder: top level joining csr, front, queue and back
// depends on wpde_pkg, wpde_csr, wpde_front, wpde_queue, wpde_back
//
// A pixel request is taken when start is high and busy is low. A request whose
// req_chain_pos is not below led_count is dropped when taken and gives no codes.
// A kept pixel is scaled in a two-stage multiply pipeline, waits in a queue of
// QUEUE_DEPTH entries, and comes out as 24 duty codes on consecutive cycles,
// green msb first and blue lsb last with rsp_last_code set. rsp_strobe marks
// each code for exactly one cycle and cannot be held off. The back end issues
// one code per cycle, and the codes of a pixel already queued follow those of
// the one before with no gap. busy rises while the pipeline and queue together
// hold QUEUE_DEPTH pixels. Registers sit at byte addresses 0 (high_code), 4 (low_code)
// and 8 (led_count) and should be written only while no pixel is in flight.

module ws2812_pixel_duty_encoder #(
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [wpde_pkg::INDEX_W-1:0]        req_chain_pos,
   input  logic [wpde_pkg::COLOR_W-1:0]        req_color,
   input  logic [wpde_pkg::PCT_W-1:0]          req_brightness,
   output logic                                rsp_strobe,
   output logic [wpde_pkg::INDEX_W-1:0]        rsp_pixel_index,
   output logic [wpde_pkg::SLOT_W-1:0]         rsp_bit_slot,
   output logic [wpde_pkg::CODE_W-1:0]         rsp_duty_code,
   output logic                                rsp_last_code,
   input  logic                                csr_psel,
   input  logic                                csr_penable,
   input  logic                                csr_pwrite,
   input  logic [wpde_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [wpde_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [wpde_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                                csr_pready
);

   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   wpde_pkg::cfg_type    cfg;
   wpde_pkg::push_type   push;
   wpde_pkg::entry_type  head;
   logic                 pop;
   logic                 q_not_empty;
   logic [CNT_W-1:0]     q_count;

   // configuration registers
   wpde_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   // request intake and scaling
   wpde_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_chain_pos  (req_chain_pos),
      .req_color      (req_color),
      .req_brightness (req_brightness),
      .cfg            (cfg),
      .q_count        (q_count),
      .push           (push)
   );

   // pixel queue
   wpde_queue #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .pop       (pop),
      .head      (head),
      .not_empty (q_not_empty),
      .count     (q_count)
   );

   // code serializer
   wpde_back u_back (
      .clock           (clock),
      .reset           (reset),
      .cfg             (cfg),
      .head            (head),
      .q_not_empty     (q_not_empty),
      .pop             (pop),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_bit_slot    (rsp_bit_slot),
      .rsp_duty_code   (rsp_duty_code),
      .rsp_last_code   (rsp_last_code)
   );

endmodule

/* src/wpde_checker.sv */
// wpde_checker: port-level checks on the duty code stream, bound to the top level
// depends on wpde_pkg and ws2812_pixel_duty_encoder

module wpde_checker (
   input logic                             clock,
   input logic                             reset,
   input logic                             rsp_strobe,
   input logic [wpde_pkg::INDEX_W-1:0]     rsp_pixel_index,
   input logic [wpde_pkg::SLOT_W-1:0]      rsp_bit_slot,
   input logic                             rsp_last_code
);

   // last marker only on the final slot
   a_last_slot: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last_code |-> rsp_bit_slot == wpde_pkg::SLOT_LAST)
      else $error("last code on a slot other than the final one");

   // a pixel's codes run on consecutive cycles with rising slots
   a_slot_step: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_code |=>
         rsp_strobe && rsp_bit_slot == $past(rsp_bit_slot) + 5'd1)
      else $error("gap or skipped slot inside a pixel");

   // pixel index holds across one pixel's codes
   a_index_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last_code |=> $stable(rsp_pixel_index))
      else $error("pixel index changed inside a pixel");

   // a new burst always starts at the first slot
   a_burst_start: assert property (@(posedge clock) disable iff (reset)
      !rsp_strobe |=> !rsp_strobe || rsp_bit_slot == 5'd0)
      else $error("code burst started past the first slot");

endmodule

bind ws2812_pixel_duty_encoder wpde_checker u_wpde_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_strobe      (rsp_strobe),
   .rsp_pixel_index (rsp_pixel_index),
   .rsp_bit_slot    (rsp_bit_slot),
   .rsp_last_code   (rsp_last_code)
);

/* verif/tb_top.sv */
// tb_top: self-checking bench for ws2812_pixel_duty_encoder, with a duty code scoreboard
// depends on wpde_pkg and ws2812_pixel_duty_encoder; drives pixel requests and csr writes

`timescale 1ns / 100ps

module tb_top;

   localparam int DRAIN_CYCLES = 8;
   localparam int IDLE_LIMIT   = 2000;
   localparam logic [1:0] REG_UNMAPPED = 2'd3;

   // predicts the 24 duty codes of each kept pixel and checks them in order
   class duty_scoreboard;
      typedef struct {
         logic [wpde_pkg::INDEX_W-1:0] pixel_index;
         logic [wpde_pkg::SLOT_W-1:0]  bit_slot;
         logic [wpde_pkg::CODE_W-1:0]  duty_code;
         logic                         last_code;
      } duty_code_type;

      duty_code_type                expected_codes[$];
      logic [wpde_pkg::CODE_W-1:0]  high_code;
      logic [wpde_pkg::CODE_W-1:0]  low_code;
      logic [wpde_pkg::INDEX_W-1:0] led_count;
      int                           errors;

      function new();
         high_code = wpde_pkg::HIGH_CODE_RST;
         low_code  = wpde_pkg::LOW_CODE_RST;
         led_count = wpde_pkg::LED_COUNT_RST;
         errors    = 0;
      endfunction

      function int pending();
         return expected_codes.size();
      endfunction

      task report(input string msg);
         if (errors < 40)
            $display("%0t mismatch: %s", $realtime, msg);
         errors++;
      endtask

      // register write as seen on the csr port, value cut to the register width
      function void write_reg(input logic [1:0] index, input logic [31:0] value);
         case (index)
            wpde_pkg::REG_HIGH_CODE: high_code = value[wpde_pkg::CODE_W-1:0];
            wpde_pkg::REG_LOW_CODE:  low_code  = value[wpde_pkg::CODE_W-1:0];
            wpde_pkg::REG_LED_COUNT: led_count = value[wpde_pkg::INDEX_W-1:0];
            default: ;
         endcase
      endfunction

      // floor(channel * percent / 100), clipped to 255
      function logic [7:0] scale_channel(input logic [7:0] ch, input logic [7:0] pct);
         int unsigned v;
         v = (int'(ch) * int'(pct)) / 100;
         return (v > 255) ? 8'hFF : v[7:0];
      endfunction

      task note_request(input logic [wpde_pkg::INDEX_W-1:0] idx,
                        input logic [wpde_pkg::COLOR_W-1:0] color,
                        input logic [wpde_pkg::PCT_W-1:0]   pct);
         logic [23:0]   grb;
         duty_code_type code;
         if (idx >= led_count)
            return;
         grb = {scale_channel(color[15:8], pct), scale_channel(color[23:16], pct),
                scale_channel(color[7:0], pct)};
         for (int k = 0; k <= int'(wpde_pkg::SLOT_LAST); k++) begin
            code.pixel_index = idx;
            code.bit_slot    = k[wpde_pkg::SLOT_W-1:0];
            code.duty_code   = grb[23-k] ? high_code : low_code;
            code.last_code   = (k == int'(wpde_pkg::SLOT_LAST));
            expected_codes.push_back(code);
         end
      endtask

      task check_code(input logic [wpde_pkg::INDEX_W-1:0] idx,
                      input logic [wpde_pkg::SLOT_W-1:0]  slot,
                      input logic [wpde_pkg::CODE_W-1:0]  duty,
                      input logic                         last);
         duty_code_type code;
         if (expected_codes.size() == 0) begin
            report($sformatf("unexpected code idx=%0d slot=%0d duty=%0d last=%0b",
                             idx, slot, duty, last));
            return;
         end
         code = expected_codes.pop_front();
         if (idx !== code.pixel_index || slot !== code.bit_slot ||
             duty !== code.duty_code || last !== code.last_code)
            report($sformatf("got idx=%0d slot=%0d duty=%0d last=%0b, want %0d %0d %0d %0b",
                             idx, slot, duty, last, code.pixel_index, code.bit_slot,
                             code.duty_code, code.last_code));
      endtask
   endclass

   logic                              clock = 1'b0;
   logic                              reset;
   logic                              start;
   logic                              busy;
   logic [wpde_pkg::INDEX_W-1:0]      req_chain_pos;
   logic [wpde_pkg::COLOR_W-1:0]      req_color;
   logic [wpde_pkg::PCT_W-1:0]        req_brightness;
   logic                              rsp_strobe;
   logic [wpde_pkg::INDEX_W-1:0]      rsp_pixel_index;
   logic [wpde_pkg::SLOT_W-1:0]       rsp_bit_slot;
   logic [wpde_pkg::CODE_W-1:0]       rsp_duty_code;
   logic                              rsp_last_code;
   logic                              csr_psel;
   logic                              csr_penable;
   logic                              csr_pwrite;
   logic [wpde_pkg::CSR_ADDR_W-1:0]   csr_paddr;
   logic [wpde_pkg::CSR_DATA_W-1:0]   csr_pwdata;
   logic [wpde_pkg::CSR_DATA_W-1:0]   csr_prdata;
   logic                              csr_pready;

   duty_scoreboard sb = new();
   int             calm_left = 0;
   int             idle_cycles = 0;

   ws2812_pixel_duty_encoder dut (
      .clock           (clock),
      .reset           (reset),
      .start           (start),
      .busy            (busy),
      .req_chain_pos   (req_chain_pos),
      .req_color       (req_color),
      .req_brightness  (req_brightness),
      .rsp_strobe      (rsp_strobe),
      .rsp_pixel_index (rsp_pixel_index),
      .rsp_bit_slot    (rsp_bit_slot),
      .rsp_duty_code   (rsp_duty_code),
      .rsp_last_code   (rsp_last_code),
      .csr_psel        (csr_psel),
      .csr_penable     (csr_penable),
      .csr_pwrite      (csr_pwrite),
      .csr_paddr       (csr_paddr),
      .csr_pwdata      (csr_pwdata),
      .csr_prdata      (csr_prdata),
      .csr_pready      (csr_pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // sample requests, codes and register writes on the edge that takes them
   always @(posedge clock) begin
      if (!reset) begin
         if (start && !busy)
            sb.note_request(req_chain_pos, req_color, req_brightness);
         if (rsp_strobe)
            sb.check_code(rsp_pixel_index, rsp_bit_slot, rsp_duty_code, rsp_last_code);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready)
            sb.write_reg(csr_paddr[3:2], csr_pwdata);
      end
   end

   // watchdog: too long without any handshake ends the run
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_strobe ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // gap before the next request, with occasional runs of back-to-back requests
   function int next_gap();
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      if ($urandom_range(0, 15) == 0)
         calm_left = $urandom_range(8, 24);
      return $urandom_range(0, 11);
   endfunction

   // one pixel request; start stays high on return so requests can follow back to back
   task send_pixel(input logic [wpde_pkg::INDEX_W-1:0] idx,
                   input logic [wpde_pkg::COLOR_W-1:0] color,
                   input logic [wpde_pkg::PCT_W-1:0]   pct);
      int gap;
      gap = next_gap();
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start          <= 1'b1;
      req_chain_pos  <= idx;
      req_color      <= color;
      req_brightness <= pct;
      do @(posedge clock); while (busy);
   endtask

   // let every expected code arrive, then wait DRAIN_CYCLES more for any dropped request
   task drain();
      start <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   // apb write: setup cycle, access cycle, then idle with psel low
   task csr_write(input logic [1:0] index, input logic [31:0] data);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task set_codes(input logic [31:0] high, input logic [31:0] low, input logic [31:0] count);
      drain();
      csr_write(wpde_pkg::REG_HIGH_CODE, high);
      csr_write(wpde_pkg::REG_LOW_CODE, low);
      csr_write(wpde_pkg::REG_LED_COUNT, count);
   endtask

   // random pixels until enough kept ones went in, or the item budget is spent
   task random_pixels(input int kept_target, input int item_budget);
      int                           kept;
      int                           sent;
      logic [wpde_pkg::INDEX_W-1:0] idx;
      logic [wpde_pkg::COLOR_W-1:0] color;
      logic [wpde_pkg::PCT_W-1:0]   pct;
      kept = 0;
      sent = 0;
      while (kept < kept_target && sent < item_budget) begin
         if (sb.led_count == 0)
            idx = $urandom_range(0, 1023);
         else if ($urandom_range(0, 9) == 0)
            idx = $urandom_range(sb.led_count, 1023);
         else
            idx = $urandom_range(0, sb.led_count - 1);
         case ($urandom_range(0, 9))
            0:       color = 24'hFFFFFF;
            1:       color = 24'h000000;
            default: color = $urandom;
         endcase
         pct = ($urandom_range(0, 9) < 7) ? $urandom_range(0, 100) : $urandom_range(0, 255);
         if (idx < sb.led_count)
            kept++;
         sent++;
         send_pixel(idx, color, pct);
      end
   endtask

   initial begin
      reset          <= 1'b1;
      start          <= 1'b0;
      req_chain_pos  <= '0;
      req_color      <= '0;
      req_brightness <= '0;
      csr_psel       <= 1'b0;
      csr_penable    <= 1'b0;
      csr_pwrite     <= 1'b0;
      csr_paddr      <= '0;
      csr_pwdata     <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed pixels on reset register values
      send_pixel(10'd0,    24'h000000, 8'd0);
      send_pixel(10'd79,   24'hFFFFFF, 8'd100);
      send_pixel(10'd80,   24'hFFFFFF, 8'd100);
      send_pixel(10'd1023, 24'h5A5A5A, 8'd50);
      send_pixel(10'd40,   24'hFFFFFF, 8'd255);
      send_pixel(10'd41,   24'h808080, 8'd101);
      send_pixel(10'd1,    24'h010101, 8'd255);
      send_pixel(10'd2,    24'hFFFFFF, 8'd1);
      send_pixel(10'd3,    24'hAA55CC, 8'd100);
      send_pixel(10'd4,    24'h123456, 8'd99);
      send_pixel(10'd5,    24'hFF0000, 8'd100);
      send_pixel(10'd6,    24'h00FF00, 8'd100);
      send_pixel(10'd7,    24'h0000FF, 8'd100);
      send_pixel(10'd78,   24'h64C832, 8'd200);
      send_pixel(10'd77,   24'hFFFFFF, 8'd0);
      send_pixel(10'd512,  24'hFFFFFF, 8'd128);
      send_pixel(10'd341,  24'h0F0F0F, 8'd255);
      random_pixels(30, 200);

      // widest high_code and led_count and a zero low_code, written with excess upper bits, plus an unmapped register
      set_codes(32'hFFFF_FFFF, 32'hABCD_FC00, 32'h0000_07FF);
      csr_write(REG_UNMAPPED, 32'h0000_0155);
      random_pixels(40, 200);

      // codes swapped to the extremes, a single led
      set_codes(32'd0, 32'd1023, 32'd1);
      random_pixels(30, 200);

      // no leds: every request is dropped
      set_codes(32'd512, 32'd1, 32'd0);
      random_pixels(1, 6);

      // random settings
      repeat (3) begin
         set_codes($urandom, $urandom, $urandom_range(1, 1023));
         random_pixels(40, 200);
      end

      drain();
      if (sb.errors == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

endmodule
